>>> rtl/lpd_pkg.sv
// Shared types and constants of the lidar packet deframer.
// Holds the frame phase encoding and the result record; depends on nothing.
`default_nettype none
package lpd_pkg;

    localparam logic [7:0]  SYNC_BYTE    = 8'hFA;
    localparam logic [7:0]  INDEX_FIRST  = 8'hA0;
    localparam logic [7:0]  INDEX_END    = 8'hDC;
    localparam logic [5:0]  POS_SPEED_LO = 6'd2;
    localparam logic [5:0]  POS_SPEED_HI = 6'd3;
    localparam logic [5:0]  POS_READ_LO  = 6'd4;
    localparam logic [5:0]  POS_READ_END = 6'd40;
    localparam logic [5:0]  POS_LAST     = 6'd41;
    localparam logic [2:0]  OFFSET_LAST  = 3'd5;
    localparam logic [2:0]  READ_LAST    = 3'd5;
    localparam logic [8:0]  ANGLE_TOP    = 9'd359;
    localparam logic [15:0] RPM_RECIP    = 16'd52429;
    localparam int          RPM_SHIFT    = 19;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_SYNC = 4'b0010,
        PH_TAKE = 4'b0100,
        PH_SKIP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [8:0]  angle_deg;
        logic [19:0] range_mm;
        logic [15:0] intensity;
        logic [12:0] motor_rpm;
        logic        last_in_packet;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/lpd_input_stage.sv
// Input register of the lidar packet deframer.
// Captures one received byte per transfer; depends on no other file.
`default_nettype none
module lpd_input_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lpd_framer.sv
// Framing state machine of the lidar packet deframer.
// Tracks sync, packet index and byte position and forms each reading; uses lpd_pkg.
`default_nettype none
module lpd_framer
    import lpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] byte_data,
    output logic            result_valid,
    output result_t         result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic [5:0]  prev_reg;
    logic [5:0]  prev_next;
    logic [7:0]  speed_lo_reg;
    logic [7:0]  speed_lo_next;
    logic [12:0] rpm_reg;
    logic [12:0] rpm_next;
    logic [23:0] reading_reg;
    logic [23:0] reading_next;
    logic [2:0]  offset_reg;
    logic [2:0]  offset_next;
    logic [2:0]  read_idx_reg;
    logic [2:0]  read_idx_next;
    logic [8:0]  slot_reg;
    logic [8:0]  slot_next;

    logic [7:0]  index_diff;
    logic [5:0]  packet;
    logic [31:0] rpm_product;
    logic [19:0] range_raw;

    assign index_diff  = byte_data - INDEX_FIRST;
    assign packet      = index_diff[5:0];
    assign rpm_product = {byte_data, speed_lo_reg} * RPM_RECIP;
    assign range_raw   = {4'b0000, byte_data, reading_reg[23:16]};

    assign result.angle_deg      = ANGLE_TOP - slot_reg;
    assign result.range_mm       = (range_raw << 3) + (range_raw << 1);
    assign result.intensity      = reading_reg[15:0];
    assign result.motor_rpm      = rpm_reg;
    assign result.last_in_packet = (read_idx_reg == READ_LAST);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        prev_next     = prev_reg;
        speed_lo_next = speed_lo_reg;
        rpm_next      = rpm_reg;
        reading_next  = reading_reg;
        offset_next   = offset_reg;
        read_idx_next = read_idx_reg;
        slot_next     = slot_reg;
        result_valid  = 1'b0;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_data == SYNC_BYTE)
                    begin
                        phase_next = PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (byte_data >= INDEX_FIRST && byte_data < INDEX_END)
                    begin
                        pos_next      = POS_SPEED_LO;
                        offset_next   = 3'd0;
                        read_idx_next = 3'd0;
                        slot_next     = {1'b0, packet, 2'b00} + {2'b00, packet, 1'b0};
                        if (packet == 6'd0 || packet > prev_reg)
                        begin
                            prev_next  = packet;
                            phase_next = PH_TAKE;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else if (byte_data != SYNC_BYTE)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_TAKE, PH_SKIP:
                begin
                    if (phase_reg == PH_TAKE)
                    begin
                        if (pos_reg == POS_SPEED_LO)
                        begin
                            speed_lo_next = byte_data;
                        end
                        else if (pos_reg == POS_SPEED_HI)
                        begin
                            rpm_next = rpm_product[RPM_SHIFT +: 13];
                        end
                        else if (pos_reg >= POS_READ_LO && pos_reg < POS_READ_END)
                        begin
                            case (offset_reg)
                                3'd0: reading_next[7:0]   = byte_data;
                                3'd1: reading_next[15:8]  = byte_data;
                                3'd2: reading_next[23:16] = byte_data;
                                3'd3: result_valid        = 1'b1;
                                default: ;
                            endcase
                            if (offset_reg == OFFSET_LAST)
                            begin
                                offset_next   = 3'd0;
                                read_idx_next = read_idx_reg + 3'd1;
                                slot_next     = slot_reg + 9'd1;
                            end
                            else
                            begin
                                offset_next = offset_reg + 3'd1;
                            end
                        end
                    end
                    if (pos_reg >= POS_LAST)
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = 6'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 6'd0;
            prev_reg  <= 6'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_lo_reg <= speed_lo_next;
        rpm_reg      <= rpm_next;
        reading_reg  <= reading_next;
        offset_reg   <= offset_next;
        read_idx_reg <= read_idx_next;
        slot_reg     <= slot_next;
    end

    a_result_only_in_take: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (phase_reg == PH_TAKE && advance))
        else $error("result formed outside an accepted packet");

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte position beyond packet length");

    a_packet_position: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAKE || phase_reg == PH_SKIP) |-> pos_reg >= POS_SPEED_LO)
        else $error("inside a packet before its speed bytes");

    a_packet_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pos_reg == POS_LAST
         && (phase_reg == PH_TAKE || phase_reg == PH_SKIP))
        |=> (phase_reg == PH_HUNT && pos_reg == 6'd0))
        else $error("packet end did not return to hunting");

endmodule
`default_nettype wire

>>> rtl/lpd_result_stage.sv
// Result register of the lidar packet deframer.
// Holds one reading until its transfer completes; uses the result_t type of lpd_pkg.
`default_nettype none
module lpd_result_stage
    import lpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire logic    load_valid,
    input  wire result_t load_result,
    output logic         space,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      held
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = load_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            result_reg <= load_result;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lidar_packet_deframer.sv
// Lidar packet deframer top level: input register, framing logic, result register.
// A byte is held in the input register, and its reading in the result register, on the way to the outputs.
// Throughput is one byte per cycle while the result side keeps taking readings.
// Reset is asynchronous and active low; it clears framing to hunting for sync.
// Depends on lpd_pkg, lpd_input_stage, lpd_framer and lpd_result_stage.
`default_nettype none
module lidar_packet_deframer
    import lpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [8:0]      angle_deg,
    output logic [19:0]     range_mm,
    output logic [15:0]     intensity,
    output logic [12:0]     motor_rpm,
    output logic            last_in_packet
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       space;
    logic       advance;
    logic       result_valid;
    result_t    result;
    result_t    held;

    assign advance = byte_valid && space;

    lpd_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    lpd_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result       (result)
    );

    lpd_result_stage u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_valid  (result_valid),
        .load_result (result),
        .space       (space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .held        (held)
    );

    assign angle_deg      = held.angle_deg;
    assign range_mm       = held.range_mm;
    assign intensity      = held.intensity;
    assign motor_rpm      = held.motor_rpm;
    assign last_in_packet = held.last_in_packet;

endmodule
`default_nettype wire
